// ===== design/ddms_pkg.sv =====
// Shared types, constants and helpers for the differential drive motion supervisor.
package ddms_pkg;

	localparam int FullTurn = 5760;
	localparam int HalfTurn = 2880;

	typedef enum logic [1:0] {
		MODE_POLL     = 2'd0,
		MODE_FORWARD  = 2'd1,
		MODE_BACKWARD = 2'd2,
		MODE_TURN     = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_GOING   = 2'd0,
		ST_REACHED = 2'd1,
		ST_TIMEOUT = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CMD_NONE = 2'd0,
		CMD_SET  = 2'd1,
		CMD_STOP = 2'd2
	} motor_cmd_t;

	typedef enum logic [2:0] {
		REG_INITIAL_HEADING   = 3'd0,
		REG_HEADING_GAIN      = 3'd1,
		REG_TURN_DEADBAND     = 3'd2,
		REG_MAX_TURN_EFFORT   = 3'd3,
		REG_DISTANCE_DEADBAND = 3'd4,
		REG_CRUISE_SPEED      = 3'd5,
		REG_MM_TO_WHEEL_DEG   = 3'd6,
		REG_WHEEL_DEG_TO_MM   = 3'd7
	} reg_index_t;

	typedef enum logic [2:0] {
		FSM_IDLE  = 3'd0,
		FSM_EVAL  = 3'd1,
		FSM_MUL_A = 3'd2,
		FSM_MUL_B = 3'd3,
		FSM_DONE  = 3'd4,
		FSM_OUT   = 3'd5
	} fsm_state_t;

	typedef struct packed {
		logic load;
		logic eval;
		logic mul_a;
		logic mul_b;
		logic finish;
	} dp_cmd_t;

	function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
		if (v > 48'sd8388607) return 24'sh7FFFFF;
		if (v < -48'sd8388608) return 24'sh800000;
		return v[23:0];
	endfunction

	function automatic logic signed [14:0] wrap_err(input logic signed [16:0] e);
		logic signed [16:0] r;
		r = e;
		if (e > 17'sd2880) begin
			if (r > 17'sd20160) r = r - 17'sd23040;
			if (r > 17'sd8640) r = r - 17'sd11520;
			if (r > 17'sd2880) r = r - 17'sd5760;
		end else if (e < -17'sd2880) begin
			if (r < -17'sd20160) r = r + 17'sd23040;
			if (r < -17'sd8640) r = r + 17'sd11520;
			if (r < -17'sd2880) r = r + 17'sd5760;
		end
		return r[14:0];
	endfunction

endpackage

// ===== design/ddms_ctrl.sv =====
// Controller state machine sequencing one item through the datapath.
module ddms_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  logic               is_start,
	output ddms_pkg::dp_cmd_t  cmd
);
	ddms_pkg::fsm_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ddms_pkg::FSM_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ddms_pkg::FSM_IDLE:  if (in_valid) state_d = is_start ? ddms_pkg::FSM_OUT : ddms_pkg::FSM_EVAL;
			ddms_pkg::FSM_EVAL:  state_d = ddms_pkg::FSM_MUL_A;
			ddms_pkg::FSM_MUL_A: state_d = ddms_pkg::FSM_MUL_B;
			ddms_pkg::FSM_MUL_B: state_d = ddms_pkg::FSM_DONE;
			ddms_pkg::FSM_DONE:  state_d = ddms_pkg::FSM_OUT;
			ddms_pkg::FSM_OUT:   if (out_ready) state_d = ddms_pkg::FSM_IDLE;
			default:             state_d = ddms_pkg::FSM_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = (state_q == ddms_pkg::FSM_IDLE);
		out_valid  = (state_q == ddms_pkg::FSM_OUT);
		cmd.load   = (state_q == ddms_pkg::FSM_IDLE) && in_valid;
		cmd.eval   = (state_q == ddms_pkg::FSM_EVAL);
		cmd.mul_a  = (state_q == ddms_pkg::FSM_MUL_A);
		cmd.mul_b  = (state_q == ddms_pkg::FSM_MUL_B);
		cmd.finish = (state_q == ddms_pkg::FSM_DONE);
	end
endmodule

// ===== design/ddms_dp.sv =====
// Datapath: registers, heading math, shared products and result registers.
module ddms_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  ddms_pkg::dp_cmd_t   cmd,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [19:0]         cfg_data,
	input  logic [1:0]          mode,
	input  logic signed [15:0]  setpoint,
	input  logic [23:0]         duration_ms,
	input  logic [31:0]         now_ms,
	input  logic [12:0]         azimuth,
	input  logic signed [23:0]  right_wheel_angle,
	output logic                is_start,
	output logic [1:0]          status,
	output logic [1:0]          motor_command,
	output logic signed [23:0]  left_velocity,
	output logic signed [23:0]  right_velocity,
	output logic signed [13:0]  heading_now
);
	logic [12:0] init_head_q;
	logic [15:0] gain_q;
	logic [11:0] turn_db_q;
	logic [19:0] max_eff_q;
	logic [9:0]  dist_db_q;
	logic [11:0] cruise_q;
	logic [15:0] mm2deg_q;
	logic [15:0] deg2mm_q;

	logic [1:0]         kind_q;
	logic signed [15:0] target_q;
	logic [23:0]        tlen_q;
	logic [31:0]        tstart_q;
	logic [23:0]        origin_q;
	logic signed [13:0] held_q;

	logic [31:0]        inow_q;
	logic [23:0]        iwheel_q;

	logic signed [13:0] h_q;
	logic signed [14:0] err_q;
	logic               tout_q;
	logic signed [39:0] prod_a_q;
	logic signed [33:0] num_p_q, num_n_q;
	logic signed [47:0] prod_b_q;
	logic signed [47:0] prod_c_q;

	logic signed [14:0] h_raw, h_w;
	logic signed [16:0] err_in;
	logic [31:0]        elapsed;
	logic signed [23:0] delta;
	logic signed [17:0] cs;
	logic signed [32:0] gain3e;
	logic signed [33:0] num_p, num_n;
	logic signed [40:0] dist_s;
	logic signed [41:0] de;
	logic signed [40:0] eff;
	logic signed [47:0] vp, vn;
	logic signed [20:0] lim;

	assign is_start = (mode != ddms_pkg::MODE_POLL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_head_q <= '0;
			gain_q      <= 16'd256;
			turn_db_q   <= 12'd16;
			max_eff_q   <= 20'd1600;
			dist_db_q   <= 10'd5;
			cruise_q    <= 12'd200;
			mm2deg_q    <= 16'd512;
			deg2mm_q    <= 16'd128;
		end else if (cfg_we) begin
			case (cfg_index)
				ddms_pkg::REG_INITIAL_HEADING:   init_head_q <= cfg_data[12:0];
				ddms_pkg::REG_HEADING_GAIN:      gain_q      <= cfg_data[15:0];
				ddms_pkg::REG_TURN_DEADBAND:     turn_db_q   <= cfg_data[11:0];
				ddms_pkg::REG_MAX_TURN_EFFORT:   max_eff_q   <= cfg_data[19:0];
				ddms_pkg::REG_DISTANCE_DEADBAND: dist_db_q   <= cfg_data[9:0];
				ddms_pkg::REG_CRUISE_SPEED:      cruise_q    <= cfg_data[11:0];
				ddms_pkg::REG_MM_TO_WHEEL_DEG:   mm2deg_q    <= cfg_data[15:0];
				ddms_pkg::REG_WHEEL_DEG_TO_MM:   deg2mm_q    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		h_raw = $signed({2'b00, init_head_q}) - $signed({2'b00, azimuth});
		h_w = h_raw;
		if (h_raw > 15'sd5760) h_w = h_raw - 15'sd5760;
		else if (h_raw < -15'sd5760) h_w = h_raw + 15'sd5760;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			inow_q   <= now_ms;
			iwheel_q <= right_wheel_angle;
			h_q      <= h_w[13:0];
		end
	end

	assign elapsed = inow_q - tstart_q;
	assign delta   = iwheel_q - origin_q;
	assign err_in  = (kind_q == ddms_pkg::MODE_TURN) ?
		(17'(target_q) - 17'(h_q)) : (17'(held_q) - 17'(h_q));

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			tout_q <= (elapsed > {8'd0, tlen_q});
			err_q  <= ddms_pkg::wrap_err(err_in);
		end
	end

	assign gain3e = $signed({1'b0, gain_q}) * $signed({{2{err_q[14]}}, err_q}) * 33'sd3;
	assign cs     = $signed({6'd0, cruise_q});
	assign num_p  = $signed({cs, 14'd0}) + 34'(gain3e);
	assign num_n  = -$signed({cs, 14'd0}) + 34'(gain3e);

	always_ff @(posedge clk) begin
		if (cmd.mul_a) begin
			prod_a_q <= 40'(delta) * 40'($signed({1'b0, deg2mm_q}));
			num_p_q  <= num_p;
			num_n_q  <= num_n;
		end
		if (cmd.mul_b) begin
			prod_b_q <= 48'(num_p_q) * 48'($signed({1'b0, mm2deg_q}));
			prod_c_q <= 48'(num_n_q) * 48'($signed({1'b0, mm2deg_q}));
		end
	end

	always_comb begin
		dist_s = (kind_q == ddms_pkg::MODE_BACKWARD) ? -41'(prod_a_q) : 41'(prod_a_q);
		de = 42'(dist_s) - ($signed(42'(target_q)) <<< 12);
		if (de < 0) de = -de;
		eff = (41'($signed({1'b0, gain_q})) * 41'(err_q)) / 41'sd256;
		lim = $signed({1'b0, max_eff_q});
		if (eff > 41'(lim)) eff = 41'(lim);
		if (eff < -41'(lim)) eff = -41'(lim);
		vp = prod_b_q / 48'sd262144;
		vn = prod_c_q / 48'sd262144;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= '0;
			target_q <= '0;
			tlen_q   <= '0;
			tstart_q <= '0;
			origin_q <= '0;
			held_q   <= '0;
		end else if (cmd.load && is_start) begin
			kind_q   <= mode;
			target_q <= setpoint;
			tlen_q   <= duration_ms;
			tstart_q <= now_ms;
			origin_q <= right_wheel_angle;
		end else if (cmd.finish && kind_q == ddms_pkg::MODE_TURN && !tout_q) begin
			held_q <= h_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status         <= ddms_pkg::ST_GOING;
			motor_command  <= ddms_pkg::CMD_NONE;
			left_velocity  <= '0;
			right_velocity <= '0;
			heading_now    <= h_w[13:0];
		end else if (cmd.finish && kind_q != ddms_pkg::MODE_POLL) begin
			if (tout_q) begin
				status        <= ddms_pkg::ST_TIMEOUT;
				motor_command <= ddms_pkg::CMD_STOP;
			end else if (kind_q == ddms_pkg::MODE_TURN) begin
				if ((err_q < 0 ? -err_q : err_q) <= $signed({3'd0, turn_db_q})) begin
					status        <= ddms_pkg::ST_REACHED;
					motor_command <= ddms_pkg::CMD_STOP;
				end else begin
					motor_command  <= ddms_pkg::CMD_SET;
					left_velocity  <= eff[23:0];
					right_velocity <= eff[23:0];
				end
			end else if (target_q != -16'sd1 &&
					de < $signed({20'd0, dist_db_q, 12'd0})) begin
				status        <= ddms_pkg::ST_REACHED;
				motor_command <= ddms_pkg::CMD_STOP;
			end else begin
				motor_command <= ddms_pkg::CMD_SET;
				if (kind_q == ddms_pkg::MODE_FORWARD) begin
					right_velocity <= ddms_pkg::sat24(vp);
					left_velocity  <= ddms_pkg::sat24(vn);
				end else begin
					left_velocity  <= ddms_pkg::sat24(vp);
					right_velocity <= ddms_pkg::sat24(vn);
				end
			end
		end
	end
endmodule

// ===== design/differential_drive_motion_supervisor_core.sv =====
// Top level of the differential drive motion supervisor.
// channel | signals                      | accepted when
// in      | in_valid, in_ready, fields   | in_valid & in_ready
// out     | out_valid, out_ready, fields | out_valid & out_ready
// cfg     | cfg_we, cfg_index, cfg_data  | cfg_we
// A poll passes through the EVAL, MUL_A, MUL_B and DONE states before OUT; a start item
// goes straight from IDLE to OUT. One item is in flight at a time.
// Reset returns the controller to IDLE, clears the command registers and loads register
// defaults, but does not reset the result registers; a stalled result holds in_ready low.
module differential_drive_motion_supervisor_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [19:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         mode,
	input  logic signed [15:0] setpoint,
	input  logic [23:0]        duration_ms,
	input  logic [31:0]        now_ms,
	input  logic [12:0]        azimuth,
	input  logic signed [23:0] right_wheel_angle,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [1:0]         motor_command,
	output logic signed [23:0] left_velocity,
	output logic signed [23:0] right_velocity,
	output logic signed [13:0] heading_now
);
	ddms_pkg::dp_cmd_t cmd;
	logic is_start;

	ddms_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.is_start, .cmd
	);

	ddms_dp u_dp (
		.clk, .arst_n, .cmd, .cfg_we, .cfg_index, .cfg_data,
		.mode, .setpoint, .duration_ms, .now_ms, .azimuth, .right_wheel_angle,
		.is_start, .status, .motor_command, .left_velocity, .right_velocity,
		.heading_now
	);
endmodule
